// ===== sv/skht_pkg.sv =====
// Shared types and constants for the sorted key histogram table.
package skht_pkg;

   localparam int OP_W    = 2;
   localparam int ID_W    = 8;
   localparam int SLOT_W  = 5;
   localparam int PARTY_W = 8;
   localparam int COUNT_W = 32;
   localparam int DIST_W  = 6;
   localparam int IDX_SUM_W = 9;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR = 2'd0,
      OP_BEGIN = 2'd1,
      OP_COUNT = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_SEL  = 3'b100
   } state_type;

   typedef struct packed {
      logic            bump;
      logic            insert;
      logic [ID_W-1:0] id;
   } cell_ctl_type;

endpackage

// ===== sv/sorted_key_histogram_table.sv =====
// Top level of the sorted key histogram table.
//
// Counts 8-bit identifiers in a table of distinct keys kept in ascending order.
// The req channel carries one operation per beat: clear, begin record (checks
// party_size against PARTY_LIMIT and sets a sticky corrupt flag), count an
// identifier, or read one slot. Every request beat yields exactly one rsp beat.
// The table is a row of TABLE_DEPTH slot cells; a count compares all cells at
// once, and on a new key each larger entry moves one cell up in the same cycle.
// The accepted request is registered, then the cells update (EXEC), then the
// selected slot goes into the output register (SEL), which raises rsp_valid.
// The block takes no new request until it is through with the last one:
// req_stall is low only in the idle state. The output register lets the next
// request be accepted while a response still waits on rsp_stall; the select
// step then holds until the output register is free.
// Reset clears the fill count, the corrupt flag, the sequencer and rsp_valid;
// slot contents are left as they are and never read before being written.
module sorted_key_histogram_table
   import skht_pkg::*;
#(
   parameter int TABLE_DEPTH = 32,
   parameter int PARTY_LIMIT = 8
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [OP_W-1:0]    req_opcode,
   input  logic [ID_W-1:0]    req_player_id,
   input  logic [SLOT_W-1:0]  req_slot,
   input  logic [PARTY_W-1:0] req_party_size,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [ID_W-1:0]    rsp_entry_key,
   output logic [COUNT_W-1:0] rsp_entry_count,
   output logic [SLOT_W-1:0]  rsp_slot_index,
   output logic [DIST_W-1:0]  rsp_distinct_count,
   output logic               rsp_table_full,
   output logic               rsp_corrupt_error
);

   localparam int USED_W = $clog2(TABLE_DEPTH + 1);

   state_type state_ff, state_in;

   op_type               op_ff;
   logic [ID_W-1:0]      id_ff;
   logic [SLOT_W-1:0]    slot_ff;
   logic [PARTY_W-1:0]   party_ff;

   logic [USED_W-1:0]    used_ff, used_in;
   logic                 err_ff, err_in;
   logic                 full_ff, full_in;
   logic [TABLE_DEPTH-1:0] hot_ff, hot_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]      key_out_ff;
   logic [COUNT_W-1:0]   count_out_ff;
   logic [SLOT_W-1:0]    idx_out_ff;
   logic                 full_out_ff;
   logic [DIST_W-1:0]    dist_out_ff;
   logic                 err_out_ff;

   logic [TABLE_DEPTH-1:0] occ, lt, eq, ins, slot_hit;
   logic [ID_W-1:0]        cell_key   [TABLE_DEPTH];
   logic [COUNT_W-1:0]     cell_count [TABLE_DEPTH];
   cell_ctl_type           ctl;

   logic                 accept;
   logic                 exec_count;
   logic                 any_eq;
   logic                 table_at_depth;
   logic                 out_free;
   logic [ID_W-1:0]      sel_key;
   logic [COUNT_W-1:0]   sel_count;
   logic [IDX_SUM_W-1:0] sel_idx;
   logic [IDX_SUM_W-1:0] used_wide;

   assign accept         = req_valid && !req_stall;
   assign req_stall      = (state_ff != ST_IDLE);
   assign any_eq         = |eq;
   assign table_at_depth = (used_ff == USED_W'(TABLE_DEPTH));
   assign exec_count     = (state_ff == ST_EXEC) && (op_ff == OP_COUNT) && !err_ff;
   assign out_free       = !rsp_valid_ff || !rsp_stall;

   assign ctl.id     = id_ff;
   assign ctl.bump   = exec_count;
   assign ctl.insert = exec_count && !any_eq && !table_at_depth;

   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      assign occ[g]      = (used_ff > USED_W'(g));
      assign slot_hit[g] = occ[g] && (int'(slot_ff) == g);
      if (g == 0) begin : g_head
         skht_cell u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .occ        (occ[g]),
            .prev_lt    (1'b1),
            .prev_key   (id_ff),
            .prev_count (COUNT_W'(1)),
            .lt         (lt[g]),
            .eq         (eq[g]),
            .ins        (ins[g]),
            .key        (cell_key[g]),
            .count      (cell_count[g])
         );
      end else begin : g_body
         skht_cell u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .occ        (occ[g]),
            .prev_lt    (lt[g-1]),
            .prev_key   (cell_key[g-1]),
            .prev_count (cell_count[g-1]),
            .lt         (lt[g]),
            .eq         (eq[g]),
            .ins        (ins[g]),
            .key        (cell_key[g]),
            .count      (cell_count[g])
         );
      end
   end

   always_comb begin
      sel_key   = '0;
      sel_count = '0;
      sel_idx   = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (hot_ff[i]) begin
            sel_key   = sel_key | cell_key[i];
            sel_count = sel_count | cell_count[i];
            sel_idx   = sel_idx | IDX_SUM_W'(i);
         end
      end
   end

   assign used_wide = IDX_SUM_W'(used_ff);

   always_comb begin
      state_in     = state_ff;
      used_in      = used_ff;
      err_in       = err_ff;
      full_in      = full_ff;
      hot_in       = hot_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            full_in  = 1'b0;
            hot_in   = '0;
            state_in = ST_SEL;
            unique case (op_ff)
               OP_CLEAR: begin
                  used_in = '0;
                  err_in  = 1'b0;
               end
               OP_BEGIN: begin
                  if (party_ff > PARTY_W'(PARTY_LIMIT)) begin
                     err_in = 1'b1;
                  end
               end
               OP_READ: begin
                  hot_in = slot_hit;
               end
               OP_COUNT: begin
                  if (!err_ff) begin
                     if (any_eq) begin
                        hot_in = eq;
                     end else if (table_at_depth) begin
                        full_in = 1'b1;
                     end else begin
                        hot_in  = ins;
                        used_in = used_ff + USED_W'(1);
                     end
                  end
               end
               default: begin
                  hot_in = '0;
               end
            endcase
         end
         ST_SEL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         err_ff       <= 1'b0;
         full_ff      <= 1'b0;
         hot_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         err_ff       <= err_in;
         full_ff      <= full_in;
         hot_ff       <= hot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= op_type'(req_opcode);
         id_ff    <= req_player_id;
         slot_ff  <= req_slot;
         party_ff <= req_party_size;
      end
      if ((state_ff == ST_SEL) && out_free) begin
         key_out_ff   <= sel_key;
         count_out_ff <= sel_count;
         idx_out_ff   <= (op_ff == OP_READ) ? slot_ff : sel_idx[SLOT_W-1:0];
         full_out_ff  <= full_ff;
         dist_out_ff  <= used_wide[DIST_W-1:0];
         err_out_ff   <= err_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_entry_key      = key_out_ff;
   assign rsp_entry_count    = count_out_ff;
   assign rsp_slot_index     = idx_out_ff;
   assign rsp_distinct_count = dist_out_ff;
   assign rsp_table_full     = full_out_ff;
   assign rsp_corrupt_error  = err_out_ff;

endmodule

// ===== sv/skht_cell.sv =====
// One table slot: holds a key and its count, compares, bumps, and shifts on insert.
module skht_cell
   import skht_pkg::*;
(
   input  logic               clock,
   input  cell_ctl_type       ctl,
   input  logic               occ,
   input  logic               prev_lt,
   input  logic [ID_W-1:0]    prev_key,
   input  logic [COUNT_W-1:0] prev_count,
   output logic               lt,
   output logic               eq,
   output logic               ins,
   output logic [ID_W-1:0]    key,
   output logic [COUNT_W-1:0] count
);

   logic [ID_W-1:0]    key_ff;
   logic [ID_W-1:0]    key_in;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;

   assign lt    = occ && (key_ff < ctl.id);
   assign eq    = occ && (key_ff == ctl.id);
   assign ins   = ctl.insert && !lt && prev_lt;
   assign key   = key_ff;
   assign count = count_ff;

   always_comb begin
      key_in   = key_ff;
      count_in = count_ff;
      if (ctl.bump && eq && (count_ff != COUNT_MAX)) begin
         count_in = count_ff + COUNT_W'(1);
      end
      if (ctl.insert && !lt) begin
         if (prev_lt) begin
            key_in   = ctl.id;
            count_in = COUNT_W'(1);
         end else begin
            key_in   = prev_key;
            count_in = prev_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      count_ff <= count_in;
   end

endmodule

// ===== sv/skht_checker.sv =====
// Port-level checks for the sorted key histogram table, bound to the top level.
module skht_checker
   import skht_pkg::*;
#(
   parameter int TABLE_DEPTH = 32
)
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [ID_W-1:0]    rsp_entry_key,
   input logic [COUNT_W-1:0] rsp_entry_count,
   input logic [SLOT_W-1:0]  rsp_slot_index,
   input logic [DIST_W-1:0]  rsp_distinct_count,
   input logic               rsp_table_full,
   input logic               rsp_corrupt_error
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_entry_key)
         && $stable(rsp_entry_count) && $stable(rsp_slot_index)
         && $stable(rsp_table_full))
      else $error("rsp beat changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid set right after reset");

   a_full_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_table_full |-> rsp_entry_key == '0 && rsp_entry_count == '0
         && rsp_slot_index == '0 && !rsp_corrupt_error)
      else $error("full response carries an entry");

   a_full_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_table_full |-> rsp_distinct_count == DIST_W'(TABLE_DEPTH))
      else $error("full response with table not at depth");

endmodule

bind sorted_key_histogram_table skht_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_skht_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_entry_key      (rsp_entry_key),
   .rsp_entry_count    (rsp_entry_count),
   .rsp_slot_index     (rsp_slot_index),
   .rsp_distinct_count (rsp_distinct_count),
   .rsp_table_full     (rsp_table_full),
   .rsp_corrupt_error  (rsp_corrupt_error)
);
